>>> src/rhss_pkg.sv
// shared hash constants, types and modular arithmetic helpers
package rhss_pkg;

    localparam int HASH_W = 30;
    localparam int BYTE_W = 8;
    localparam int POS_W = 32;

    typedef logic [HASH_W-1:0] hash_t;
    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [POS_W-1:0] pos_t;

    localparam hash_t HASH_MOD = 30'd1000000007;
    localparam hash_t HASH_ONE = 30'd1;

    // multiplier bits handled in each cycle by the modular multiply unit
    localparam int MUL_STEPS = 2;
    localparam int MUL_CYCLES = BYTE_W / MUL_STEPS;
    localparam int MCNT_W = (MUL_CYCLES > 1) ? $clog2(MUL_CYCLES) : 1;

    localparam logic FUNC_PATTERN = 1'b0;
    localparam logic FUNC_TEXT = 1'b1;

    function automatic hash_t mod_dbl(hash_t x);
        logic [HASH_W:0] y;
        y = {x, 1'b0};
        if (y >= {1'b0, HASH_MOD})
        begin
            y = y - {1'b0, HASH_MOD};
        end
        return y[HASH_W-1:0];
    endfunction

    function automatic hash_t mod_add(hash_t a, hash_t b);
        logic [HASH_W:0] y;
        y = {1'b0, a} + {1'b0, b};
        if (y >= {1'b0, HASH_MOD})
        begin
            y = y - {1'b0, HASH_MOD};
        end
        return y[HASH_W-1:0];
    endfunction

    // both operands below the modulus, so the 30-bit wrap lands on the right value
    function automatic hash_t mod_sub(hash_t a, hash_t b);
        hash_t y;
        if (a >= b)
        begin
            y = a - b;
        end
        else
        begin
            y = a - b + HASH_MOD;
        end
        return y;
    endfunction

    // one horner step: 2t + bit*a mod p
    function automatic hash_t mul_step(hash_t t, logic bitv, hash_t a);
        return mod_add(mod_dbl(t), bitv ? a : '0);
    endfunction

endpackage

>>> src/rolling_hash_string_search.sv
// Rabin-Karp streaming string search over a pattern store and a text window ring.
// Pattern bytes (func 0) are stored and hashed base 256 mod 1000000007; a byte with last
// set ends the load and restarts the text. Text bytes (func 1) roll the window hash and
// give one result transaction each; on a hash hit the window is compared byte by byte
// with the pattern, so only exact matches report their start index. Pattern bytes beyond
// MAX_PATTERN are dropped and flagged on every later result until a new load. A stored
// pattern byte runs the multiply and finish states; a dropped one keeps the block idle. A
// text byte reads the leaving ring byte, multiplies, finishes and outputs, comparing the
// window on a hit; with no pattern it goes straight to output. The multiply unit handles two
// multiplier bits a cycle, the ring read is registered, the compare takes one byte a cycle.
// A finished result waits in the output register while the next byte is taken.
module rolling_hash_string_search
    import rhss_pkg::*;
#(
    parameter int MAX_PATTERN = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic        func,
    input  logic [7:0]  data_byte,
    input  logic        last,
    output logic        result_valid,
    input  logic        result_stall,
    output logic        matched,
    output logic [31:0] match_position,
    output logic        end_of_text,
    output logic        pattern_overflow
);

    localparam int AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int LW = $clog2(MAX_PATTERN + 1);
    localparam logic [LW-1:0] LEN_MAX = LW'(MAX_PATTERN);
    localparam logic [AW-1:0] PTR_LAST = AW'(MAX_PATTERN - 1);
    localparam logic [AW:0] RING_DEPTH = (AW + 1)'(MAX_PATTERN);
    localparam pos_t POS_MAX = '1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RDOLD = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_FIN   = 3'd3;
    localparam logic [2:0] S_VER   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    function automatic logic [AW-1:0] ptr_inc(logic [AW-1:0] p);
        return (p == PTR_LAST) ? '0 : p + AW'(1);
    endfunction

    // memories
    byte_t ring_mem [MAX_PATTERN];
    byte_t store_mem [MAX_PATTERN];
    byte_t ring_rd_reg;
    byte_t store_rd_reg;
    logic ring_we;
    logic store_we;
    logic [AW-1:0] ring_ra;
    logic [AW-1:0] ring_wa;
    logic [AW-1:0] store_wa;
    logic [AW-1:0] store_ra;

    // control and search state
    logic [2:0] state_reg, state_next;
    logic loading_reg, loading_next;
    logic ovf_reg, ovf_next;
    logic [LW-1:0] len_reg, len_next;
    hash_t ph_reg, ph_next;
    hash_t pow_reg, pow_next;
    hash_t wh_reg, wh_next;
    pos_t pos_reg, pos_next;
    logic [AW-1:0] rp_reg, rp_next;
    logic result_valid_reg, result_valid_next;

    // per-transaction working registers
    logic kind_reg, kind_next;
    byte_t byte_reg, byte_next;
    logic last_reg, last_next;
    pos_t cur_pos_reg, cur_pos_next;
    logic use_old_reg, use_old_next;
    logic [AW-1:0] base_reg, base_next;
    hash_t s_reg, s_next;
    hash_t t_reg, t_next;
    byte_t m_reg, m_next;
    logic [MCNT_W-1:0] mcnt_reg, mcnt_next;
    logic [LW-1:0] vcnt_reg, vcnt_next;
    logic [AW-1:0] vaddr_reg, vaddr_next;
    logic pend_reg, pend_next;
    logic same_reg, same_next;
    logic res_match_reg, res_match_next;
    pos_t res_pos_reg, res_pos_next;
    logic matched_reg, matched_next;
    pos_t match_position_reg, match_position_next;
    logic end_of_text_reg, end_of_text_next;
    logic pattern_overflow_reg, pattern_overflow_next;

    // combinational helpers
    logic [AW-1:0] rp_eff;
    pos_t pos_eff;
    hash_t wh_eff;
    logic [LW-1:0] len_eff;
    logic [AW:0] old_sum;
    logic [AW-1:0] old_idx;
    hash_t wh_new;
    logic hit;
    logic [POS_W:0] pos_plus;
    hash_t s_step;
    hash_t t_step;
    byte_t m_step;
    logic out_load;

    assign byte_stall = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign matched = matched_reg;
    assign match_position = match_position_reg;
    assign end_of_text = end_of_text_reg;
    assign pattern_overflow = pattern_overflow_reg;

    assign ring_wa = rp_eff;
    assign store_wa = AW'(len_eff);
    assign store_ra = AW'(vcnt_reg);

    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[ring_wa] <= data_byte;
        end
        ring_rd_reg <= ring_mem[ring_ra];
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_mem[store_wa] <= data_byte;
        end
        store_rd_reg <= store_mem[store_ra];
    end

    // two multiplier bits a cycle: s doubles, t runs horner over m against pow
    always_comb
    begin
        s_step = s_reg;
        t_step = t_reg;
        m_step = m_reg;
        for (int k = 0; k < MUL_STEPS; k++)
        begin
            s_step = mod_dbl(s_step);
            t_step = mul_step(t_step, m_step[BYTE_W-1], pow_reg);
            m_step = {m_step[BYTE_W-2:0], 1'b0};
        end
    end

    always_comb
    begin
        // a text byte during a load restarts the text first
        rp_eff = loading_reg ? '0 : rp_reg;
        pos_eff = loading_reg ? '0 : pos_reg;
        wh_eff = loading_reg ? '0 : wh_reg;
        len_eff = loading_reg ? len_reg : '0;

        // ring entry that drops out of the window
        old_sum = (AW + 1)'(rp_eff) + RING_DEPTH - (AW + 1)'(len_reg);
        if (old_sum >= RING_DEPTH)
        begin
            old_sum = old_sum - RING_DEPTH;
        end
        old_idx = old_sum[AW-1:0];

        wh_new = mod_add(mod_sub(s_reg, t_reg), HASH_W'(byte_reg));
        pos_plus = {1'b0, cur_pos_reg} + (POS_W + 1)'(1);
        hit = (pos_plus >= (POS_W + 1)'(len_reg)) && (wh_new == ph_reg);

        state_next = state_reg;
        loading_next = loading_reg;
        ovf_next = ovf_reg;
        len_next = len_reg;
        ph_next = ph_reg;
        pow_next = pow_reg;
        wh_next = wh_reg;
        pos_next = pos_reg;
        rp_next = rp_reg;
        kind_next = kind_reg;
        byte_next = byte_reg;
        last_next = last_reg;
        cur_pos_next = cur_pos_reg;
        use_old_next = use_old_reg;
        base_next = base_reg;
        s_next = s_reg;
        t_next = t_reg;
        m_next = m_reg;
        mcnt_next = mcnt_reg;
        vcnt_next = vcnt_reg;
        vaddr_next = vaddr_reg;
        pend_next = pend_reg;
        same_next = same_reg;
        res_match_next = res_match_reg;
        res_pos_next = res_pos_reg;
        ring_we = 1'b0;
        store_we = 1'b0;
        ring_ra = vaddr_reg;
        out_load = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                ring_ra = old_idx;
                if (byte_valid)
                begin
                    byte_next = data_byte;
                    last_next = last;
                    kind_next = func;
                    if (func == FUNC_PATTERN)
                    begin
                        loading_next = 1'b1;
                        if (!loading_reg)
                        begin
                            ph_next = '0;
                            pow_next = HASH_ONE;
                            ovf_next = 1'b0;
                        end
                        len_next = len_eff;
                        if (len_eff < LEN_MAX)
                        begin
                            store_we = 1'b1;
                            len_next = len_eff + LW'(1);
                            s_next = loading_reg ? ph_reg : '0;
                            t_next = loading_reg ? pow_reg : HASH_ONE;
                            m_next = '0;
                            mcnt_next = '0;
                            state_next = S_MUL;
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                        if (last)
                        begin
                            loading_next = 1'b0;
                            pos_next = '0;
                            wh_next = '0;
                            rp_next = '0;
                        end
                    end
                    else
                    begin
                        loading_next = 1'b0;
                        ring_we = 1'b1;
                        base_next = old_idx;
                        cur_pos_next = pos_eff;
                        use_old_next = (pos_eff >= POS_W'(len_reg));
                        rp_next = last ? '0 : ptr_inc(rp_eff);
                        if (last)
                        begin
                            pos_next = '0;
                        end
                        else if (pos_eff == POS_MAX)
                        begin
                            pos_next = pos_eff;
                        end
                        else
                        begin
                            pos_next = pos_eff + POS_W'(1);
                        end
                        s_next = wh_eff;
                        t_next = '0;
                        mcnt_next = '0;
                        wh_next = last ? '0 : wh_eff;
                        if (len_reg == '0)
                        begin
                            res_match_next = 1'b0;
                            res_pos_next = '0;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            state_next = S_RDOLD;
                        end
                    end
                end
            end

            S_RDOLD:
            begin
                m_next = use_old_reg ? ring_rd_reg : '0;
                state_next = S_MUL;
            end

            S_MUL:
            begin
                s_next = s_step;
                t_next = t_step;
                m_next = m_step;
                mcnt_next = mcnt_reg + MCNT_W'(1);
                if (mcnt_reg == MCNT_W'(MUL_CYCLES - 1))
                begin
                    state_next = S_FIN;
                end
            end

            S_FIN:
            begin
                if (kind_reg == FUNC_PATTERN)
                begin
                    ph_next = mod_add(s_reg, HASH_W'(byte_reg));
                    pow_next = t_reg;
                    state_next = S_IDLE;
                end
                else
                begin
                    wh_next = last_reg ? '0 : wh_new;
                    res_pos_next = pos_plus[POS_W-1:0] - POS_W'(len_reg);
                    if (hit)
                    begin
                        vcnt_next = '0;
                        vaddr_next = ptr_inc(base_reg);
                        pend_next = 1'b0;
                        same_next = 1'b1;
                        state_next = S_VER;
                    end
                    else
                    begin
                        res_match_next = 1'b0;
                        res_pos_next = '0;
                        state_next = S_OUT;
                    end
                end
            end

            S_VER:
            begin
                // each read goes out in the cycle before its compare
                pend_next = (vcnt_reg < len_reg);
                if (vcnt_reg < len_reg)
                begin
                    vcnt_next = vcnt_reg + LW'(1);
                    vaddr_next = ptr_inc(vaddr_reg);
                end
                if (pend_reg && (ring_rd_reg != store_rd_reg))
                begin
                    same_next = 1'b0;
                end
                if ((vcnt_reg == len_reg) && !pend_reg)
                begin
                    res_match_next = same_reg;
                    if (!same_reg)
                    begin
                        res_pos_next = '0;
                    end
                    state_next = S_OUT;
                end
            end

            S_OUT:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    out_load = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        matched_next = matched_reg;
        match_position_next = match_position_reg;
        end_of_text_next = end_of_text_reg;
        pattern_overflow_next = pattern_overflow_reg;
        if (out_load)
        begin
            result_valid_next = 1'b1;
            matched_next = res_match_reg;
            match_position_next = res_pos_reg;
            end_of_text_next = last_reg;
            pattern_overflow_next = ovf_reg;
        end
        else if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            loading_reg <= 1'b0;
            ovf_reg <= 1'b0;
            len_reg <= '0;
            ph_reg <= '0;
            pow_reg <= HASH_ONE;
            wh_reg <= '0;
            pos_reg <= '0;
            rp_reg <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            loading_reg <= loading_next;
            ovf_reg <= ovf_next;
            len_reg <= len_next;
            ph_reg <= ph_next;
            pow_reg <= pow_next;
            wh_reg <= wh_next;
            pos_reg <= pos_next;
            rp_reg <= rp_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        byte_reg <= byte_next;
        last_reg <= last_next;
        cur_pos_reg <= cur_pos_next;
        use_old_reg <= use_old_next;
        base_reg <= base_next;
        s_reg <= s_next;
        t_reg <= t_next;
        m_reg <= m_next;
        mcnt_reg <= mcnt_next;
        vcnt_reg <= vcnt_next;
        vaddr_reg <= vaddr_next;
        pend_reg <= pend_next;
        same_reg <= same_next;
        res_match_reg <= res_match_next;
        res_pos_reg <= res_pos_next;
        matched_reg <= matched_next;
        match_position_reg <= match_position_next;
        end_of_text_reg <= end_of_text_next;
        pattern_overflow_reg <= pattern_overflow_next;
    end

endmodule

>>> src/rhss_checker.sv
// port-level checker for the string search block and its bind
module rhss_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        byte_valid,
    input logic        byte_stall,
    input logic        func,
    input logic [7:0]  data_byte,
    input logic        last,
    input logic        result_valid,
    input logic        result_stall,
    input logic        matched,
    input logic [31:0] match_position,
    input logic        end_of_text,
    input logic        pattern_overflow
);

    // a stalled result transaction stays
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result transaction dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(matched) && $stable(match_position)
            && $stable(end_of_text) && $stable(pattern_overflow))
        else $error("stalled result payload changed");

    // a miss reports position zero
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !matched |-> match_position == 32'd0)
        else $error("miss with nonzero position");

    // an accepted text byte always leaves the block busy and stalling further bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && !byte_stall && func |=> byte_stall)
        else $error("text byte finished in one cycle");

    // a new result appears only after the block was busy
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(byte_stall))
        else $error("result without a busy cycle");

endmodule

bind rolling_hash_string_search rhss_checker u_rhss_checker (.*);
